[sv/cfe_pkg.sv]
// Shared constants and types of the COBS frame encoder.
package cfe_pkg;

  localparam int BYTES_PER_RESULT = 4;
  localparam int LANES = (BYTES_PER_RESULT < 1) ? 1 :
                         (BYTES_PER_RESULT > 4) ? 4 : BYTES_PER_RESULT;
  localparam int MAX_RESULTS = 64;
  localparam int RES_W = $clog2(MAX_RESULTS);

  localparam logic [7:0] FULL_CODE  = 8'hff;
  localparam logic [7:0] START_CODE = 8'h01;
  localparam logic [7:0] TRAIL_CODE = 8'h01;

  localparam int SLOT_W    = 8;
  localparam int RAM_DEPTH = 2 * (1 << SLOT_W);
  localparam int RAM_AW    = SLOT_W + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] SEL_CODE  = 2'd0;
  localparam logic [1:0] SEL_STORE = 2'd1;
  localparam logic [1:0] SEL_ONE   = 2'd2;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  typedef struct packed {
    logic       bank;
    logic [7:0] code;
    logic       trail;
    logic       fend;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

[sv/cfe_ifs.sv]
// Valid/ready channel interfaces for raw input bytes and encoded results.
interface cfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, output data_byte, output frame_end, input ready);
  modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface cfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;
  logic [2:0] lane_count;
  logic       run_last;
  logic       frame_done;

  modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
                  output out_byte3, output lane_count, output run_last,
                  output frame_done, input ready);
  modport sink (input valid, input out_byte0, input out_byte1, input out_byte2,
                input out_byte3, input lane_count, input run_last,
                input frame_done, output ready);
endinterface

[sv/cfe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/cfe_front.sv]
// Front end: accepts raw bytes, buffers the open run and issues flush commands.
module cfe_front (
  input  logic                      clk,
  input  logic                      rst,
  cfe_in_if.sink                    raw,
  output logic                      push,
  output cfe_pkg::cmd_t             push_cmd,
  input  logic                      q_full,
  input  cfe_pkg::rel_t             rel,
  output logic                      we,
  output logic [cfe_pkg::RAM_AW-1:0] waddr,
  output logic [7:0]                wdata
);
  import cfe_pkg::*;

  logic [7:0] code;
  logic [7:0] code_next;
  logic       wbank;
  logic [1:0] busy;
  logic [1:0] busy_next;
  logic       take;
  logic       nz;
  logic       full;
  logic       flush;
  logic [7:0] code_inc;

  assign raw.ready = !busy[wbank] && !q_full;
  assign take      = raw.valid && raw.ready;
  assign nz        = raw.data_byte != 8'd0;
  assign code_inc  = code + 8'd1;
  assign full      = nz && (code_inc == FULL_CODE);
  assign flush     = !nz || full || raw.frame_end;

  assign we    = take && nz;
  assign waddr = {wbank, code - 8'd1};
  assign wdata = raw.data_byte;

  assign push           = take && flush;
  assign push_cmd.bank  = wbank;
  assign push_cmd.code  = nz ? code_inc : code;
  assign push_cmd.trail = !nz && raw.frame_end;
  assign push_cmd.fend  = raw.frame_end;

  always_comb begin
    code_next = code;
    if (take) begin
      code_next = flush ? START_CODE : code_inc;
    end
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (push) begin
      busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code  <= START_CODE;
      wbank <= 1'b0;
      busy  <= 2'b00;
    end else begin
      code <= code_next;
      busy <= busy_next;
      if (push) begin
        wbank <= ~wbank;
      end
    end
  end

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    code >= START_CODE && code < FULL_CODE)
    else $error("run code out of range");

  a_write_free_bank: assert property (@(posedge clk) disable iff (rst)
    we |-> !busy[wbank] && !(rel.valid && rel.bank == wbank))
    else $error("write into a bank still being drained");

endmodule

[sv/cfe_cmd_fifo.sv]
// Short command queue between the front end and the back end.
module cfe_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cfe_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output cfe_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import cfe_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] cnt;

  assign full    = cnt == QCNT_W'(QUEUE_DEPTH);
  assign empty   = cnt == '0;
  assign pop_cmd = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_cmd;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + QPTR_W'(1);
      end
      if (pop) begin
        rp <= rp + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt <= cnt - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push |-> !full) and (pop |-> !empty))
    else $error("command queue overrun or underrun");

endmodule

[sv/cfe_back.sv]
// Back end: replays a flushed run from the buffer and packs bytes into results.
module cfe_back (
  input  logic                       clk,
  input  logic                       rst,
  input  cfe_pkg::cmd_t              pop_cmd,
  input  logic                       q_empty,
  output logic                       pop,
  output cfe_pkg::rel_t              rel,
  output logic                       re,
  output logic [cfe_pkg::RAM_AW-1:0] raddr,
  input  logic [7:0]                 rdata,
  cfe_out_if.source                  enc
);
  import cfe_pkg::*;

  logic             st;
  cmd_t             cur;
  logic [7:0]       pos;
  logic [7:0]       last_pos;
  logic             a_last;
  logic             adv;

  logic             b_valid;
  logic [1:0]       b_sel;
  logic [7:0]       b_code;
  logic             b_last;
  logic             b_fend;
  logic [7:0]       b_byte;
  logic             b_emit;
  logic             stall;
  logic             consume;

  logic [3:0][7:0]  acc;
  logic [2:0]       acc_cnt;
  logic [RES_W-1:0] res_cnt;
  logic             dropping;
  logic             res_last;
  logic [3:0][7:0]  lane;

  logic             ovalid;
  logic [3:0][7:0]  obytes;
  logic [2:0]       ocount;
  logic             olast;
  logic             odone;

  assign a_last = pos == last_pos;
  assign pop    = (st == ST_IDLE) && !q_empty;

  always_comb begin
    case (b_sel)
      SEL_CODE: b_byte = b_code;
      SEL_ONE:  b_byte = TRAIL_CODE;
      default:  b_byte = rdata;
    endcase
  end

  assign b_emit   = b_valid && !dropping && ((acc_cnt == 3'(LANES - 1)) || b_last);
  assign stall    = b_emit && ovalid && !enc.ready;
  assign adv      = (st == ST_RUN) && !stall;
  assign consume  = b_valid && !stall;
  assign res_last = b_last || (res_cnt == RES_W'(MAX_RESULTS - 1));

  assign re        = adv;
  assign raddr     = {cur.bank, pos - 8'd1};
  assign rel.valid = adv && a_last;
  assign rel.bank  = cur.bank;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (k < LANES && 3'(k) < acc_cnt) begin
        lane[k] = acc[k];
      end else if (k < LANES && 3'(k) == acc_cnt) begin
        lane[k] = b_byte;
      end else begin
        lane[k] = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur      <= pop_cmd;
      pos      <= 8'd0;
      last_pos <= pop_cmd.code - 8'd1 + {7'd0, pop_cmd.trail};
    end else if (adv) begin
      pos <= pos + 8'd1;
    end
    if (!stall) begin
      b_code <= cur.code;
      b_fend <= cur.fend;
      b_last <= a_last;
      if (pos == 8'd0) begin
        b_sel <= SEL_CODE;
      end else if (cur.trail && a_last) begin
        b_sel <= SEL_ONE;
      end else begin
        b_sel <= SEL_STORE;
      end
    end
    if (consume && !dropping && !b_emit) begin
      acc[acc_cnt[1:0]] <= b_byte;
    end
    if (b_emit && (!ovalid || enc.ready)) begin
      obytes <= lane;
      ocount <= acc_cnt + 3'd1;
      olast  <= res_last;
      odone  <= res_last && b_fend;
    end
    if (rst) begin
      st       <= ST_IDLE;
      b_valid  <= 1'b0;
      acc_cnt  <= 3'd0;
      res_cnt  <= '0;
      dropping <= 1'b0;
      ovalid   <= 1'b0;
    end else begin
      if (pop) begin
        st <= ST_RUN;
      end else if (adv && a_last) begin
        st <= ST_IDLE;
      end
      if (!stall) begin
        b_valid <= adv;
      end
      if (consume) begin
        if (dropping) begin
          if (b_last) begin
            dropping <= 1'b0;
          end
        end else if (b_emit) begin
          acc_cnt <= 3'd0;
          res_cnt <= res_last ? '0 : res_cnt + RES_W'(1);
          if (res_last && !b_last) begin
            dropping <= 1'b1;
          end
        end else begin
          acc_cnt <= acc_cnt + 3'd1;
        end
      end
      if (b_emit && (!ovalid || enc.ready)) begin
        ovalid <= 1'b1;
      end else if (enc.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  assign enc.valid      = ovalid;
  assign enc.out_byte0  = obytes[0];
  assign enc.out_byte1  = obytes[1];
  assign enc.out_byte2  = obytes[2];
  assign enc.out_byte3  = obytes[3];
  assign enc.lane_count = ocount;
  assign enc.run_last   = olast;
  assign enc.frame_done = odone;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    ovalid |-> ocount >= 3'd1 && ocount <= 3'(LANES))
    else $error("result lane count out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    stall |=> b_valid && $stable(b_last) && $stable(acc_cnt) && $stable(b_sel))
    else $error("pipeline moved while the result register was blocked");

endmodule

[sv/cobs_frame_encoder_top.sv]
// COBS frame encoder: raw frame bytes in, packed encoded bytes out, no delimiter.
//
// Channel raw takes one frame byte per beat, frame_end set on the last byte.
// Channel enc delivers up to four encoded bytes per beat; lane_count gives
// how many lanes hold data, run_last marks the last beat caused by one input
// beat and frame_done the last beat of an encoded frame.
// Non-zero bytes are stored in one of two 256-byte run banks while the run
// code counts up. A zero byte, a full 254-byte run or frame_end flushes the
// bank: a command enters a two-entry queue and the replay engine reads the
// bank back at one encoded byte per cycle while enc does not stall, up to
// four bytes per result beat. Input rate: one byte per cycle while the write
// bank is free and the queue has room; a flush of n stored bytes is replayed
// as its code byte, the n bytes and, for a frame ending in a zero, a trailing
// code byte, through the single RAM read port; each command starts from idle.
// When enc stalls, the result register holds, replay stops, and raw keeps
// filling the other bank until it must flush into a busy bank.
// Reset returns the run code to 1 and empties queue and output; the run
// banks are not cleared, as only written entries are ever read.
module cobs_frame_encoder_top (
  input  logic      clk,
  input  logic      rst,
  cfe_in_if.sink    raw,
  cfe_out_if.source enc
);
  import cfe_pkg::*;

  logic              push;
  cmd_t              push_cmd;
  logic              q_full;
  logic              pop;
  cmd_t              pop_cmd;
  logic              q_empty;
  rel_t              rel;
  logic              we;
  logic [RAM_AW-1:0] waddr;
  logic [7:0]        wdata;
  logic              re;
  logic [RAM_AW-1:0] raddr;
  logic [7:0]        rdata;

  cfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .raw      (raw),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full),
    .rel      (rel),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata)
  );

  cfe_cmd_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  cfe_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_run_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  cfe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .pop_cmd (pop_cmd),
    .q_empty (q_empty),
    .pop     (pop),
    .rel     (rel),
    .re      (re),
    .raddr   (raddr),
    .rdata   (rdata),
    .enc     (enc)
  );

endmodule
